// File: rtl/rbcw_pkg.sv
// ============================================================================
// rbcw_pkg: shared types and constants for the congestion window core
// Holds default parameter values, register reset values, register indexes
// and the sequencer state type.
// ============================================================================
package rbcw_pkg;

    localparam int FRAC_BITS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int TIME_W      = 32;
    localparam int WINDOW_W    = 8;
    localparam int WEIGHT_W    = 9;
    localparam int FLOOR_W     = 16;
    localparam int IN_FLIGHT_W = 16;
    localparam int WCNT_W      = 4;
    localparam int ROUND_SHIFT = 8;

    localparam logic [WINDOW_W-1:0] MAX_WINDOW_RESET  = 8'd80;
    localparam logic [WINDOW_W-1:0] MIN_WINDOW_RESET  = 8'd5;
    localparam logic [WEIGHT_W-1:0] EWMA_WEIGHT_RESET = 9'd77;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE        = 9'd256;
    localparam logic [FLOOR_W-1:0]  RATE_FLOOR_RESET  = 16'd77;
    localparam logic [TIME_W-1:0]   MIN_RTT_RESET     = 32'd80;

    localparam logic [1:0] REG_MAX_WINDOW  = 2'd0;
    localparam logic [1:0] REG_MIN_WINDOW  = 2'd1;
    localparam logic [1:0] REG_EWMA_WEIGHT = 2'd2;
    localparam logic [1:0] REG_RATE_FLOOR  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACK_DIFF,
        ST_ACK_GAP,
        ST_ACK_DELTA,
        ST_EWMA,
        ST_ACK_AVG,
        ST_DIV_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/rate_based_congestion_window_core.sv
// ============================================================================
// rate_based_congestion_window_core: sender congestion window estimator
// Tracks outstanding datagrams, minimum round-trip time and an averaged
// receiver gap; after each request it reports the window and in-flight count.
// A sent request goes straight to the bit-serial divider (34+FRAC_BITS steps); an
// ack request first updates the minimum round-trip time and then the gap average
// with a 9-step weight multiply. One request is handled at a time: a new one is
// accepted only after the result has been loaded into the output register.
// A finished result waits in the output register while the next request runs.
// Reset (rst_n low, asynchronous) restores configuration, control and estimator state.
// ============================================================================
module rate_based_congestion_window_core #(
    parameter int FRAC_BITS   = rbcw_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = rbcw_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rbcw_pkg::PADDR_W-1:0]        paddr,
    input  logic [rbcw_pkg::PDATA_W-1:0]        pwdata,
    output logic [rbcw_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [rbcw_pkg::TIME_W-1:0]         acked_send_time,
    input  logic [rbcw_pkg::TIME_W-1:0]         acked_recv_time,
    input  logic [rbcw_pkg::TIME_W-1:0]         ack_arrival_time,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rbcw_pkg::WINDOW_W-1:0]       window,
    output logic [rbcw_pkg::IN_FLIGHT_W-1:0]    in_flight
);

    localparam int TW     = rbcw_pkg::TIME_W;
    localparam int AW     = TW + FRAC_BITS;          // gap average width
    localparam int PW     = AW + 10;                 // weighted delta accumulator
    localparam int NW     = TW + FRAC_BITS + 2;      // dividend width
    localparam int DW     = TW + FRAC_BITS + 1;      // divisor width
    localparam int DCNT_W = $clog2(NW + 1);
    localparam int WW     = rbcw_pkg::WINDOW_W;

    localparam logic [AW-1:0] AVG_RESET = AW'(((12 << FRAC_BITS) + 2) / 5);
    localparam logic [PW-1:0] ROUND_ADD = PW'(1 << (rbcw_pkg::ROUND_SHIFT - 1));

    // configuration registers
    logic [WW-1:0]                    max_window_reg;
    logic [WW-1:0]                    min_window_reg;
    logic [rbcw_pkg::WEIGHT_W-1:0]    ewma_weight_reg;
    logic [rbcw_pkg::FLOOR_W-1:0]     rate_floor_reg;
    logic                             cfg_write;

    // control and estimator state
    rbcw_pkg::state_t                 state_reg, state_next;
    logic                             out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0]           count_reg, count_next;
    logic [TW-1:0]                    min_rtt_reg, min_rtt_next;
    logic [AW-1:0]                    avg_reg, avg_next;
    logic [TW-1:0]                    last_reg, last_next;
    logic                             seen_reg, seen_next;

    // datapath temporaries
    logic [TW-1:0]                    sent_reg, recv_reg, arr_reg;
    logic [TW-1:0]                    rtt_reg;
    logic                             rtt_ok_reg;
    logic [TW-1:0]                    gap_raw_reg;
    logic                             gap_use_reg;
    logic [AW-1:0]                    gap_reg;
    logic [AW:0]                      delta_reg;
    logic [PW-1:0]                    acc_reg;
    logic [rbcw_pkg::WEIGHT_W-1:0]    w_shift_reg;
    logic [rbcw_pkg::WCNT_W-1:0]      wcnt_reg;
    logic [NW-1:0]                    num_reg;
    logic [DW-1:0]                    div_reg;
    logic [DW-1:0]                    rem_reg;
    logic [WW-1:0]                    q_reg;
    logic                             sticky_reg;
    logic [DCNT_W-1:0]                dcnt_reg;
    logic [WW-1:0]                    window_reg;
    logic [rbcw_pkg::IN_FLIGHT_W-1:0] in_flight_reg;

    // combinational helpers
    logic                             accept;
    logic                             out_free;
    logic                             out_load;
    logic [TW:0]                      rtt_diff;
    logic [TW:0]                      gap_diff;
    logic [AW-1:0]                    gap_shifted;
    logic [AW-1:0]                    floor_ext;
    logic [AW-1:0]                    gap_sel;
    logic [rbcw_pkg::WEIGHT_W-1:0]    w_eff;
    logic [PW-1:0]                    delta_ext;
    logic [PW-1:0]                    avg_sum;
    logic [NW-1:0]                    num_init;
    logic [DW:0]                      trial;
    logic [DW+1:0]                    trial_diff;
    logic                             trial_fits;
    logic [WW-1:0]                    est;
    logic                             drain;
    logic [WW-1:0]                    window_calc;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_window_reg  <= rbcw_pkg::MAX_WINDOW_RESET;
            min_window_reg  <= rbcw_pkg::MIN_WINDOW_RESET;
            ewma_weight_reg <= rbcw_pkg::EWMA_WEIGHT_RESET;
            rate_floor_reg  <= rbcw_pkg::RATE_FLOOR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                rbcw_pkg::REG_MAX_WINDOW:  max_window_reg  <= pwdata[WW-1:0];
                rbcw_pkg::REG_MIN_WINDOW:  min_window_reg  <= pwdata[WW-1:0];
                rbcw_pkg::REG_EWMA_WEIGHT: ewma_weight_reg <= pwdata[rbcw_pkg::WEIGHT_W-1:0];
                rbcw_pkg::REG_RATE_FLOOR:  rate_floor_reg  <= pwdata[rbcw_pkg::FLOOR_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rbcw_pkg::REG_MAX_WINDOW:  prdata = rbcw_pkg::PDATA_W'(max_window_reg);
            rbcw_pkg::REG_MIN_WINDOW:  prdata = rbcw_pkg::PDATA_W'(min_window_reg);
            rbcw_pkg::REG_EWMA_WEIGHT: prdata = rbcw_pkg::PDATA_W'(ewma_weight_reg);
            rbcw_pkg::REG_RATE_FLOOR:  prdata = rbcw_pkg::PDATA_W'(rate_floor_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rbcw_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = operation ? rbcw_pkg::ST_ACK_DIFF : rbcw_pkg::ST_DIV_LOAD;
            end
            rbcw_pkg::ST_ACK_DIFF:  state_next = rbcw_pkg::ST_ACK_GAP;
            rbcw_pkg::ST_ACK_GAP:   state_next = rbcw_pkg::ST_ACK_DELTA;
            rbcw_pkg::ST_ACK_DELTA: state_next = rbcw_pkg::ST_EWMA;
            rbcw_pkg::ST_EWMA:
            begin
                if (wcnt_reg == rbcw_pkg::WCNT_W'(1))
                    state_next = rbcw_pkg::ST_ACK_AVG;
            end
            rbcw_pkg::ST_ACK_AVG:   state_next = rbcw_pkg::ST_DIV_LOAD;
            rbcw_pkg::ST_DIV_LOAD:  state_next = rbcw_pkg::ST_DIV;
            rbcw_pkg::ST_DIV:
            begin
                if (dcnt_reg == DCNT_W'(1))
                    state_next = rbcw_pkg::ST_FINISH;
            end
            rbcw_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = rbcw_pkg::ST_IDLE;
            end
            default:                state_next = rbcw_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            rbcw_pkg::ST_IDLE:   in_ready = 1'b1;
            rbcw_pkg::ST_FINISH: out_load = out_free;
            default:
            begin
                in_ready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // ------------------------------------------------------------------
    // arithmetic
    // ------------------------------------------------------------------
    assign rtt_diff    = {1'b0, arr_reg} - {1'b0, sent_reg};
    assign gap_diff    = {1'b0, recv_reg} - {1'b0, last_reg};
    assign gap_shifted = gap_use_reg ? {gap_raw_reg, {FRAC_BITS{1'b0}}} : '0;
    assign floor_ext   = AW'(rate_floor_reg);
    assign gap_sel     = (gap_shifted < floor_ext) ? floor_ext : gap_shifted;
    assign w_eff       = ewma_weight_reg[rbcw_pkg::WEIGHT_W-1] ? rbcw_pkg::WEIGHT_ONE
                                                               : ewma_weight_reg;
    assign delta_ext   = w_shift_reg[rbcw_pkg::WEIGHT_W-1]
                         ? {{(PW-AW-1){delta_reg[AW]}}, delta_reg} : '0;
    assign avg_sum     = {2'b00, avg_reg, {rbcw_pkg::ROUND_SHIFT{1'b0}}} + acc_reg
                         + ROUND_ADD;
    assign num_init    = {1'b0, min_rtt_reg, {(FRAC_BITS + 1){1'b0}}} + NW'(avg_reg);
    assign trial       = {rem_reg, num_reg[NW-1]};
    assign trial_diff  = {1'b0, trial} - {2'b00, div_reg};
    assign trial_fits  = !trial_diff[DW+1];

    assign est         = (sticky_reg || (q_reg > max_window_reg)) ? max_window_reg : q_reg;
    assign drain       = count_reg > COUNT_WIDTH'(est);
    assign window_calc = drain ? '0 : ((est > min_window_reg) ? est : min_window_reg);

    // ------------------------------------------------------------------
    // estimator state
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (!operation && (count_reg != '1))
                count_next = count_reg + COUNT_WIDTH'(1);
            else if (operation && (count_reg != '0))
                count_next = count_reg - COUNT_WIDTH'(1);
        end
    end

    always_comb
    begin
        min_rtt_next   = min_rtt_reg;
        avg_next       = avg_reg;
        last_next      = last_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
        if (state_reg == rbcw_pkg::ST_ACK_DIFF)
        begin
            last_next = recv_reg;
            seen_next = 1'b1;
        end
        if ((state_reg == rbcw_pkg::ST_ACK_GAP) && rtt_ok_reg && (rtt_reg < min_rtt_reg))
            min_rtt_next = rtt_reg;
        if (state_reg == rbcw_pkg::ST_ACK_AVG)
            avg_next = avg_sum[AW+rbcw_pkg::ROUND_SHIFT-1:rbcw_pkg::ROUND_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbcw_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            min_rtt_reg   <= rbcw_pkg::MIN_RTT_RESET;
            avg_reg       <= AVG_RESET;
            last_reg      <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            min_rtt_reg   <= min_rtt_next;
            avg_reg       <= avg_next;
            last_reg      <= last_next;
            seen_reg      <= seen_next;
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rbcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    sent_reg <= acked_send_time;
                    recv_reg <= acked_recv_time;
                    arr_reg  <= ack_arrival_time;
                end
            end
            rbcw_pkg::ST_ACK_DIFF:
            begin
                rtt_reg     <= rtt_diff[TW-1:0];
                rtt_ok_reg  <= !rtt_diff[TW];
                gap_raw_reg <= gap_diff[TW-1:0];
                gap_use_reg <= seen_reg && !gap_diff[TW];
            end
            rbcw_pkg::ST_ACK_GAP:
            begin
                gap_reg <= gap_sel;
            end
            rbcw_pkg::ST_ACK_DELTA:
            begin
                delta_reg   <= {1'b0, gap_reg} - {1'b0, avg_reg};
                acc_reg     <= '0;
                w_shift_reg <= w_eff;
                wcnt_reg    <= rbcw_pkg::WCNT_W'(rbcw_pkg::WEIGHT_W);
            end
            rbcw_pkg::ST_EWMA:
            begin
                // weight bits, most significant first
                acc_reg     <= {acc_reg[PW-2:0], 1'b0} + delta_ext;
                w_shift_reg <= {w_shift_reg[rbcw_pkg::WEIGHT_W-2:0], 1'b0};
                wcnt_reg    <= wcnt_reg - rbcw_pkg::WCNT_W'(1);
            end
            rbcw_pkg::ST_DIV_LOAD:
            begin
                num_reg    <= num_init;
                div_reg    <= {avg_reg, 1'b0};
                rem_reg    <= '0;
                q_reg      <= '0;
                sticky_reg <= 1'b0;
                dcnt_reg   <= DCNT_W'(NW);
            end
            rbcw_pkg::ST_DIV:
            begin
                // one quotient bit per step; saturate above the window range
                rem_reg    <= trial_fits ? trial_diff[DW-1:0] : trial[DW-1:0];
                num_reg    <= {num_reg[NW-2:0], 1'b0};
                q_reg      <= {q_reg[WW-2:0], trial_fits};
                sticky_reg <= sticky_reg || q_reg[WW-1];
                dcnt_reg   <= dcnt_reg - DCNT_W'(1);
            end
            rbcw_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    window_reg    <= window_calc;
                    in_flight_reg <= rbcw_pkg::IN_FLIGHT_W'(count_reg);
                end
            end
            default:
            begin
                sticky_reg <= sticky_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign window    = window_reg;
    assign in_flight = in_flight_reg;

endmodule

// File: rtl/rbcw_checker.sv
// ============================================================================
// rbcw_checker: port-level checks for the congestion window core
// Watches the request, result and configuration ports over time.
// ============================================================================
module rbcw_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [rbcw_pkg::PADDR_W-1:0]     paddr,
    input logic [rbcw_pkg::PDATA_W-1:0]     pwdata,
    input logic [rbcw_pkg::PDATA_W-1:0]     prdata,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [rbcw_pkg::WINDOW_W-1:0]    window,
    input logic [rbcw_pkg::IN_FLIGHT_W-1:0] in_flight
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(window) && $stable(in_flight))
        else $error("result changed while stalled");

    // drop ready once a request is taken
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    // no result right after a request
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // read back the window cap after a write
    a_cap_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[3:2] == rbcw_pkg::REG_MAX_WINDOW)
        |=> (paddr != $past(paddr)) || pwrite
            || (prdata[rbcw_pkg::WINDOW_W-1:0] == $past(pwdata[rbcw_pkg::WINDOW_W-1:0])))
        else $error("window cap read back wrong");

endmodule

bind rate_based_congestion_window_core rbcw_checker u_rbcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .window    (window),
    .in_flight (in_flight)
);

// File: dv/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for rate_based_congestion_window_core
// Drives sent and ack requests over a valid/ready channel with random idle
// bursts on both sides and programs the four registers over the APB-style
// port between phases. A scoreboard class tracks the in-flight count, the
// minimum round-trip time and the averaged receiver gap, derives the expected
// window for every accepted request and compares it field by field with each
// accepted result, in order.
// ============================================================================
typedef struct packed {
    logic [rbcw_pkg::WINDOW_W-1:0]    window;
    logic [rbcw_pkg::IN_FLIGHT_W-1:0] in_flight;
} window_result_t;

class window_scoreboard;
    localparam int FRAC  = rbcw_pkg::FRAC_BITS_DEF;
    localparam int CNT_W = rbcw_pkg::COUNT_WIDTH_DEF;
    localparam int AVG_W = 32 + FRAC;

    bit [rbcw_pkg::WINDOW_W-1:0] max_win;
    bit [rbcw_pkg::WINDOW_W-1:0] min_win;
    bit [rbcw_pkg::WEIGHT_W-1:0] weight;
    bit [rbcw_pkg::FLOOR_W-1:0]  gap_floor;

    bit [CNT_W-1:0]              count;
    bit [31:0]                   min_rtt;
    bit [AVG_W-1:0]              gap_avg;
    bit [31:0]                   last_recv;
    bit                          seen_ack;

    window_result_t              expected_windows[$];
    int                          mismatches;
    int                          checked;

    function new();
        max_win    = rbcw_pkg::MAX_WINDOW_RESET;
        min_win    = rbcw_pkg::MIN_WINDOW_RESET;
        weight     = rbcw_pkg::EWMA_WEIGHT_RESET;
        gap_floor  = rbcw_pkg::RATE_FLOOR_RESET;
        count      = '0;
        min_rtt    = rbcw_pkg::MIN_RTT_RESET;
        gap_avg    = AVG_W'(((64'd12 << FRAC) + 64'd2) / 64'd5);
        last_recv  = '0;
        seen_ack   = 1'b0;
        mismatches = 0;
        checked    = 0;
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    function void write_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            rbcw_pkg::REG_MAX_WINDOW:  max_win   = val[rbcw_pkg::WINDOW_W-1:0];
            rbcw_pkg::REG_MIN_WINDOW:  min_win   = val[rbcw_pkg::WINDOW_W-1:0];
            rbcw_pkg::REG_EWMA_WEIGHT: weight    = val[rbcw_pkg::WEIGHT_W-1:0];
            rbcw_pkg::REG_RATE_FLOOR:  gap_floor = val[rbcw_pkg::FLOOR_W-1:0];
            default: ;
        endcase
    endfunction

    function void note_request(logic op, logic [31:0] sent, logic [31:0] recv,
                               logic [31:0] arrived);
        bit [63:0]      gap;
        bit [63:0]      w;
        bit [63:0]      num;
        bit [63:0]      est;
        bit [63:0]      sum;
        window_result_t res;
        if (op == 1'b0)
        begin
            if (count != {CNT_W{1'b1}})
                count++;
        end
        else
        begin
            if (count != 0)
                count--;
            if (arrived >= sent && (arrived - sent) < min_rtt)
                min_rtt = arrived - sent;
            if (seen_ack && recv >= last_recv)
                gap = {32'd0, recv - last_recv} << FRAC;
            else
                gap = 64'd0;
            if (gap < {48'd0, gap_floor})
                gap = {48'd0, gap_floor};
            w = (weight > rbcw_pkg::WEIGHT_ONE) ? 64'(rbcw_pkg::WEIGHT_ONE) : 64'(weight);
            sum = w * gap + (64'(rbcw_pkg::WEIGHT_ONE) - w) * 64'(gap_avg)
                + (64'd1 << (rbcw_pkg::ROUND_SHIFT - 1));
            gap_avg = sum[rbcw_pkg::ROUND_SHIFT +: AVG_W];
            last_recv = recv;
            seen_ack  = 1'b1;
        end
        if (gap_avg == 0)
            est = 64'(max_win);
        else
        begin
            num = (64'(min_rtt) << (FRAC + 1)) + 64'(gap_avg);
            est = num / (64'(gap_avg) << 1);
            if (est > 64'(max_win))
                est = 64'(max_win);
        end
        if (64'(count) > est)
            res.window = '0;
        else
            res.window = (est > 64'(min_win)) ? est[7:0] : min_win;
        res.in_flight = count[rbcw_pkg::IN_FLIGHT_W-1:0];
        expected_windows.push_back(res);
    endfunction

    task check_result(logic [7:0] win, logic [15:0] infl);
        window_result_t exp_res;
        if (expected_windows.size() == 0)
        begin
            report($sformatf("result window=%0d in_flight=%0d with no request pending",
                             win, infl));
            return;
        end
        exp_res = expected_windows.pop_front();
        checked++;
        if (win !== exp_res.window)
            report($sformatf("result %0d window got %0d want %0d",
                             checked, win, exp_res.window));
        if (infl !== exp_res.in_flight)
            report($sformatf("result %0d in_flight got %0d want %0d",
                             checked, infl, exp_res.in_flight));
    endtask

    function int pending();
        return expected_windows.size();
    endfunction
endclass

module tb_top;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [rbcw_pkg::PADDR_W-1:0]     paddr = '0;
    logic [rbcw_pkg::PDATA_W-1:0]     pwdata = '0;
    logic [rbcw_pkg::PDATA_W-1:0]     prdata;
    logic                             pready;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic                             operation = 1'b0;
    logic [rbcw_pkg::TIME_W-1:0]      acked_send_time = '0;
    logic [rbcw_pkg::TIME_W-1:0]      acked_recv_time = '0;
    logic [rbcw_pkg::TIME_W-1:0]      ack_arrival_time = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [rbcw_pkg::WINDOW_W-1:0]    window;
    logic [rbcw_pkg::IN_FLIGHT_W-1:0] in_flight;

    window_scoreboard       sb = new();
    bit                     idle_on = 1'b1;
    bit                     allow_idle = 1'b1;
    int                     stall_left = 0;
    int                     n_requests = 0;
    int                     n_acks = 0;
    int                     n_settings = 0;
    int                     target_flight = 0;
    logic [31:0]            snd_clock = 32'd3000;
    logic [31:0]            rcv_clock = 32'd0;
    logic [31:0]            send_times[$];

    rate_based_congestion_window_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .acked_send_time  (acked_send_time),
        .acked_recv_time  (acked_recv_time),
        .ack_arrival_time (ack_arrival_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .window           (window),
        .in_flight        (in_flight)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                stall_left = $urandom_range(0, 7);
            end
            else
                out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(window, in_flight);
    end

    task automatic send_request(logic op, logic [31:0] sent, logic [31:0] recv,
                                logic [31:0] arrived);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid         = 1'b1;
        operation        = op;
        acked_send_time  = sent;
        acked_recv_time  = recv;
        ack_arrival_time = arrived;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(op, sent, recv, arrived);
        n_requests++;
        if (op)
            n_acks++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = rbcw_pkg::PADDR_W'({idx, 2'b00});
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(int mx, int mn, int w, int fl);
        wait_idle();
        apb_write(rbcw_pkg::REG_MAX_WINDOW, mx);
        apb_write(rbcw_pkg::REG_MIN_WINDOW, mn);
        apb_write(rbcw_pkg::REG_EWMA_WEIGHT, w);
        apb_write(rbcw_pkg::REG_RATE_FLOOR, fl);
        n_settings++;
    endtask

    task automatic run_traffic(int n, int noise_pct, int rtt_lo);
        logic [31:0] sent;
        for (int i = 0; i < n; i++)
        begin
            if (i % 32 == 0)
            begin
                target_flight = $urandom_range(0, int'(sb.max_win) + 8);
                idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < noise_pct)
                send_request(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
            else if (send_times.size() < target_flight)
            begin
                snd_clock += $urandom_range(0, 5);
                send_times.push_back(snd_clock);
                send_request(1'b0, $urandom, $urandom, $urandom);
            end
            else
            begin
                if (send_times.size() != 0)
                    sent = send_times.pop_front();
                else
                    sent = snd_clock - $urandom_range(0, 50);
                rcv_clock += $urandom_range(0, 12);
                if ($urandom_range(0, 19) == 0)
                    rcv_clock += $urandom_range(13, 2000);
                send_request(1'b1, sent, rcv_clock, sent + $urandom_range(rtt_lo, 300));
            end
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings, directed corners
        n_settings = 1;
        send_request(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_request(1'b0, 32'd0, 32'd0, 32'd0);
        send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(1'b0, $urandom, $urandom, $urandom);
        send_request(1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_request(1'b1, 32'd1000, 32'd5000, 32'd1060);
        send_request(1'b1, 32'd1010, 32'd4000, 32'd1080);
        send_request(1'b1, 32'd1020, 32'd5003, 32'd1100);
        send_request(1'b0, 32'd0, 32'd0, 32'd0);
        send_request(1'b0, 32'd0, 32'd0, 32'd0);
        send_request(1'b1, 32'd0, 32'd5003, 32'hFFFF_FFFF);
        send_request(1'b1, 32'd2000, 32'hFFFF_FFFF, 32'd1999);
        send_request(1'b1, 32'd2100, 32'd0, 32'd2150);
        repeat (4) send_request(1'b0, $urandom, $urandom, $urandom);
        send_request(1'b1, 32'd2200, 32'd10, 32'd2260);

        rcv_clock = $urandom;
        configure(255, 0, 256, 1);
        run_traffic(150, 15, 20);

        configure(1, 255, 0, 65535);
        run_traffic(100, 15, 20);

        // zero gap average: floor cleared, weight over one
        configure(200, 3, 511, 0);
        send_request(1'b1, snd_clock, rcv_clock, snd_clock + 40);
        send_request(1'b1, snd_clock, rcv_clock, snd_clock + 45);
        run_traffic(100, 15, 20);

        configure($urandom_range(1, 255), $urandom_range(0, 255), $urandom_range(0, 256),
                  $urandom_range(1, 65535));
        run_traffic(40, 15, 20);
        // hold the sender until every result is back
        wait_idle();
        run_traffic(35, 15, 20);
        configure($urandom_range(1, 255), $urandom_range(0, 255), $urandom_range(0, 256),
                  $urandom_range(1, 2000));
        run_traffic(75, 15, 20);

        allow_idle = 1'b0;
        idle_on    = 1'b0;
        configure(int'(rbcw_pkg::MAX_WINDOW_RESET), int'(rbcw_pkg::MIN_WINDOW_RESET),
                  int'(rbcw_pkg::EWMA_WEIGHT_RESET), int'(rbcw_pkg::RATE_FLOOR_RESET));
        run_traffic(100, 10, 0);

        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("covered %0d requests (%0d acks) across %0d register settings",
                 n_requests, n_acks, n_settings);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: filelist.f
rtl/rbcw_pkg.sv
rtl/rate_based_congestion_window_core.sv
rtl/rbcw_checker.sv
dv/tb_top.sv
